>>> hdl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the sliding window reorder receiver.
// ----------------------------------------------------------------------------
package swr_pkg;

    // default sizes
    localparam int DEF_FLOWS = 8;
    localparam int DEF_SLOTS = 128;

    // configuration reset value
    localparam logic [7:0] READ_LIMIT_RESET = 8'd128;

    // input function codes
    localparam logic [1:0] FUNC_PKT     = 2'd0;
    localparam logic [1:0] FUNC_BURST   = 2'd1;
    localparam logic [1:0] FUNC_CONSUME = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    // field widths
    localparam int SEQ_W  = 32;
    localparam int FLOW_W = 3;
    localparam int WIN_W  = 8;
    localparam int RES_W  = FLOW_W + SEQ_W + WIN_W + 1;

    // classified command kinds
    typedef enum logic [1:0] {
        CMD_PKT,
        CMD_BURST,
        CMD_CONSUME
    } t_cmd_kind;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PKT,
        ST_BURST_SCAN,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_EMIT,
        ST_CONS_SCAN,
        ST_CONS_CLR
    } t_back_state;

endpackage

>>> hdl/swr_fifo.sv
// ----------------------------------------------------------------------------
// swr_fifo
// Small register queue with push/pop handshake and combinational head.
// ----------------------------------------------------------------------------
module swr_fifo
    import swr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> hdl/swr_front.sv
// ----------------------------------------------------------------------------
// swr_front
// Accepts input items, classifies them, computes the slot index of a packet
// and queues the resulting command for the back end.
// ----------------------------------------------------------------------------
module swr_front
    import swr_pkg::*;
#(
    parameter int FLOWS = DEF_FLOWS,
    parameter int SLOTS = DEF_SLOTS,
    parameter int FW    = 3,
    parameter int SW    = 7,
    parameter int CMD_W = 2 + FW + SEQ_W + SW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init_done,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_func,
    input  logic [FLOW_W-1:0] i_flow,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic              i_cmd_pop,
    output logic [CMD_W-1:0]  o_cmd,
    output logic              o_cmd_empty
);

    localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    t_cmd_kind        r_kind;
    logic [FW-1:0]    r_flow;
    logic [SEQ_W-1:0] r_seq;
    logic             r_keep;
    logic             r_hold;
    logic [3:0]       r_cnt;
    logic [SW-1:0]    r_rem;

    t_cmd_kind        n_kind;
    logic             n_keep;
    logic [SEQ_W-1:0] seq_m1;
    logic [SEQ_W-1:0] rseq_m1;
    logic [2:0]       dig;
    logic [3:0]       nib;
    logic [SW+3:0]    wide;
    logic [SW+3:0]    step;
    logic             done;
    logic             release_item;
    logic             cmd_push;
    logic             cmd_full;
    logic             accept;

    // classify the incoming item
    always_comb begin
        n_kind = CMD_PKT;
        n_keep = 1'b0;
        case (i_func)
            FUNC_PKT: begin
                n_kind = CMD_PKT;
                n_keep = (32'(i_flow) < FLOWS);
            end
            FUNC_BURST: begin
                n_kind = CMD_BURST;
                n_keep = 1'b1;
            end
            FUNC_CONSUME: begin
                n_kind = CMD_CONSUME;
                n_keep = 1'b1;
            end
            default: begin
                n_kind = CMD_PKT;
                n_keep = 1'b0;
            end
        endcase
    end

    assign seq_m1  = i_seq - 1'b1;
    assign rseq_m1 = r_seq - 1'b1;
    assign dig     = 3'(r_cnt - 1'b1);
    assign nib     = rseq_m1[{dig, 2'b00} +: 4];
    assign wide    = {r_rem, nib};

    // one radix-16 step of the modulo reduction, top nibble first
    always_comb begin
        step = wide;
        for (int k = 1; k < 16; k++) begin
            if (wide >= (SW+4)'(k * SLOTS)) begin
                step = wide - (SW+4)'(k * SLOTS);
            end
        end
    end

    assign done         = (r_cnt == '0);
    assign cmd_push     = r_hold && done && r_keep;
    assign release_item = r_hold && done && (!r_keep || !cmd_full);
    assign full         = !i_init_done || (r_hold && !release_item);
    assign accept       = push && !full;

    // hold the item until its command is queued or, if it is not kept, dropped
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind;
            r_flow <= FW'(i_flow);
            r_seq  <= i_seq;
            r_keep <= n_keep;
            r_rem  <= POW2 ? seq_m1[SW-1:0] : '0;
        end else if (r_hold && !done) begin
            r_rem <= SW'(step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_cnt  <= '0;
        end else if (accept) begin
            r_hold <= 1'b1;
            r_cnt  <= POW2 ? 4'd0 : 4'd8;
        end else begin
            if (release_item) begin
                r_hold <= 1'b0;
            end
            if (r_hold && !done) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    swr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({r_kind, r_flow, r_seq, r_rem}),
        .o_full  (cmd_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

>>> hdl/swr_back.sv
// ----------------------------------------------------------------------------
// swr_back
// Executes queued commands against the reorder store and per-flow state,
// and produces acks.
// ----------------------------------------------------------------------------
module swr_back
    import swr_pkg::*;
#(
    parameter int FLOWS = DEF_FLOWS,
    parameter int SLOTS = DEF_SLOTS,
    parameter int FW    = 3,
    parameter int SW    = 7,
    parameter int CMD_W = 2 + FW + SEQ_W + SW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_read_limit,
    output logic             o_init_done,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output logic [RES_W-1:0] o_res,
    output logic             o_res_push,
    input  logic             i_res_full
);

    localparam int DEPTH = FLOWS * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KW    = (CW > WIN_W) ? CW : WIN_W;
    localparam int MAXF  = FLOWS - 1;

    // reorder store: valid mark over sequence number
    logic [SEQ_W:0] r_mem [DEPTH];
    logic [SEQ_W:0] r_rdata;

    // per-flow state
    logic [SEQ_W-1:0] r_next   [FLOWS];
    logic [SW-1:0]    r_nslot  [FLOWS];
    logic [SEQ_W-1:0] r_rp     [FLOWS];
    logic [SW-1:0]    r_rpslot [FLOWS];
    logic [CW-1:0]    r_buf    [FLOWS];
    logic [FLOWS-1:0] r_got;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [AW-1:0]    r_clr;
    logic [FW-1:0]    r_flow;
    logic [SEQ_W-1:0] r_seq;
    logic [SW-1:0]    r_slot;
    logic [SEQ_W-1:0] r_pos;
    logic [SW-1:0]    r_pslot;
    logic [CW-1:0]    r_n;
    logic [CW-1:0]    r_k;

    t_cmd_kind        cmd_kind;
    logic [FW-1:0]    cmd_flow;
    logic [SEQ_W-1:0] cmd_seq;
    logic [SW-1:0]    cmd_slot;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [SEQ_W:0]   mem_wd;
    logic             mem_re;
    logic [AW-1:0]    mem_ra;

    logic             flow_max;
    logic             later_got;
    logic             pkt_store;
    logic             walk_match;
    logic [KW-1:0]    k_min;
    logic [KW-1:0]    buf_x;
    logic [KW-1:0]    lim_x;
    logic [KW:0]      win_x;
    logic [SW-1:0]    pslot_inc;
    logic [SW-1:0]    rpslot_inc;

    function automatic logic [AW-1:0] slot_addr(input logic [FW-1:0] f,
                                                 input logic [SW-1:0] s);
        return AW'(AW'(f) * AW'(SLOTS)) + AW'(s);
    endfunction

    assign cmd_kind = t_cmd_kind'(i_cmd[CMD_W-1 -: 2]);
    assign {cmd_flow, cmd_seq, cmd_slot} = i_cmd[CMD_W-3:0];

    // flow-level conditions
    assign flow_max   = (r_flow == FW'(MAXF));
    assign pkt_store  = (r_seq >= r_next[r_flow]) && !r_rdata[SEQ_W];
    assign walk_match = r_rdata[SEQ_W] && (r_rdata[SEQ_W-1:0] == r_pos);
    assign buf_x      = KW'(r_buf[r_flow]);
    assign lim_x      = KW'(i_read_limit);
    assign k_min      = (buf_x < lim_x) ? buf_x : lim_x;
    assign win_x      = (KW+1)'(SLOTS) - (KW+1)'(r_buf[r_flow]);

    // slot of (pos-1) follows pos, including the 32-bit wrap
    assign pslot_inc  = (r_pos == '0) ? '0 :
                        (r_pslot == SW'(SLOTS - 1)) ? '0 : r_pslot + 1'b1;
    assign rpslot_inc = (r_rp[r_flow] == '1) ? '0 :
                        (r_rpslot[r_flow] == SW'(SLOTS - 1)) ? '0 :
                        r_rpslot[r_flow] + 1'b1;

    // any flow above the current one still waiting for an ack
    always_comb begin
        later_got = 1'b0;
        for (int j = 0; j < FLOWS; j++) begin
            if (r_got[j] && (FW'(j) > r_flow)) begin
                later_got = 1'b1;
            end
        end
    end

    assign o_res = {FLOW_W'(r_flow), r_pos - 1'b1, win_x[WIN_W-1:0], !later_got};
    assign o_init_done = (r_state != ST_CLEAR);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    case (cmd_kind)
                        CMD_PKT:     n_state = ST_PKT;
                        CMD_BURST:   n_state = ST_BURST_SCAN;
                        CMD_CONSUME: n_state = ST_CONS_SCAN;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PKT: n_state = ST_IDLE;
            ST_BURST_SCAN: begin
                if (r_got[r_flow]) begin
                    n_state = ST_WALK_RD;
                end else if (flow_max) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                n_state = (r_n == CW'(SLOTS)) ? ST_EMIT : ST_WALK_CMP;
            end
            ST_WALK_CMP: begin
                n_state = walk_match ? ST_WALK_RD : ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    n_state = (!later_got || flow_max) ? ST_IDLE : ST_BURST_SCAN;
                end
            end
            ST_CONS_SCAN: begin
                if (k_min != '0) begin
                    n_state = ST_CONS_CLR;
                end else if (flow_max) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CONS_CLR: begin
                if (r_k == CW'(1)) begin
                    n_state = flow_max ? ST_IDLE : ST_CONS_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory, queue and result controls
    always_comb begin
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            ST_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                mem_re    = !i_cmd_empty && (cmd_kind == CMD_PKT);
                mem_ra    = slot_addr(cmd_flow, cmd_slot);
            end
            ST_PKT: begin
                mem_we = pkt_store;
                mem_wa = slot_addr(r_flow, r_slot);
                mem_wd = {1'b1, r_seq};
            end
            ST_WALK_RD: begin
                mem_re = (r_n != CW'(SLOTS));
                mem_ra = slot_addr(r_flow, r_pslot);
            end
            ST_EMIT: begin
                o_res_push = !i_res_full;
            end
            ST_CONS_CLR: begin
                mem_we = 1'b1;
                mem_wa = slot_addr(r_flow, r_rpslot[r_flow]);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // reorder store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // command fields
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && !i_cmd_empty) begin
            r_seq  <= cmd_seq;
            r_slot <= cmd_slot;
        end
    end

    // walk and consume counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_BURST_SCAN: begin
                r_pos   <= r_next[r_flow];
                r_pslot <= r_nslot[r_flow];
                r_n     <= '0;
            end
            ST_WALK_CMP: begin
                if (walk_match) begin
                    r_pos   <= r_pos + 1'b1;
                    r_pslot <= pslot_inc;
                    r_n     <= r_n + 1'b1;
                end
            end
            ST_CONS_SCAN: r_k <= CW'(k_min);
            ST_CONS_CLR:  r_k <= r_k - 1'b1;
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // sequencer and per-flow state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_flow  <= '0;
            r_got   <= '0;
            for (int f = 0; f < FLOWS; f++) begin
                r_next[f]   <= SEQ_W'(1);
                r_nslot[f]  <= '0;
                r_rp[f]     <= '0;
                r_rpslot[f] <= '0;
                r_buf[f]    <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_flow <= (cmd_kind == CMD_PKT) ? cmd_flow : '0;
                    end
                end
                ST_PKT: begin
                    r_got[r_flow] <= 1'b1;
                    if (pkt_store && (r_buf[r_flow] < CW'(SLOTS))) begin
                        r_buf[r_flow] <= r_buf[r_flow] + 1'b1;
                    end
                end
                ST_BURST_SCAN: begin
                    if (!r_got[r_flow]) begin
                        if (flow_max) begin
                            r_got <= '0;
                        end else begin
                            r_flow <= r_flow + 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!i_res_full) begin
                        r_next[r_flow]  <= r_pos;
                        r_nslot[r_flow] <= r_pslot;
                        if (!later_got || flow_max) begin
                            r_got <= '0;
                        end else begin
                            r_flow <= r_flow + 1'b1;
                        end
                    end
                end
                ST_CONS_SCAN: begin
                    if (k_min == '0 && !flow_max) begin
                        r_flow <= r_flow + 1'b1;
                    end
                end
                ST_CONS_CLR: begin
                    r_rp[r_flow]     <= r_rp[r_flow] + 1'b1;
                    r_rpslot[r_flow] <= rpslot_inc;
                    r_buf[r_flow]    <= r_buf[r_flow] - 1'b1;
                    if (r_k == CW'(1) && !flow_max) begin
                        r_flow <= r_flow + 1'b1;
                    end
                end
                default: begin
                    r_flow <= r_flow;
                end
            endcase
        end
    end

    // buffered count of the selected flow stays within the store
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf[r_flow] <= CW'(SLOTS))
        else $error("buffered count exceeds slot count");

    // a compare always follows its read
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK_CMP) |-> ($past(r_state) == ST_WALK_RD))
        else $error("walk compare without read");

    // acks go only to flows that saw packets
    a_ack_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> r_got[r_flow])
        else $error("ack for a flow without packets");

    // a consume step never releases from an empty flow
    a_cons_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONS_CLR) |-> (r_buf[r_flow] != '0 && r_k != '0))
        else $error("release from empty flow");

endmodule

>>> hdl/sliding_window_reorder_receiver.sv
// ----------------------------------------------------------------------------
// sliding_window_reorder_receiver
// Per-flow receive window with reorder store and cumulative acks.
// ----------------------------------------------------------------------------
// After reset the block sweeps all FLOWS*SLOTS entries of its reorder store
// (1024 by default) and holds full high meanwhile; configuration writes are
// taken at any time. In the back end a packet does one store read and one
// write through the single store port, overlapped with front end work; with
// a SLOTS that is not a power of two the front end adds a radix-16 slot index
// reduction, top nibble first, per item. An end-of-burst starts from idle,
// scans the flows, reads and compares each slot (the matching run plus the
// slot that ends it) and writes one ack per flow that saw packets, with
// stalls while the result queue is full. A consume starts from idle, scans
// each flow and clears each released slot. All store reads and writes go
// through the one store port.
// ----------------------------------------------------------------------------
module sliding_window_reorder_receiver
    import swr_pkg::*;
#(
    parameter int FLOWS = DEF_FLOWS,
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_func,
    input  logic [FLOW_W-1:0] i_flow,
    input  logic [SEQ_W-1:0]  i_seq,
    output logic              empty,
    input  logic              pop,
    output logic [FLOW_W-1:0] o_ack_flow,
    output logic [SEQ_W-1:0]  o_ack_number,
    output logic [WIN_W-1:0]  o_window,
    output logic              o_last
);

    localparam int FW    = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CMD_W = 2 + FW + SEQ_W + SW;

    logic [7:0]       r_read_limit;
    logic             init_done;
    logic [CMD_W-1:0] cmd;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [RES_W-1:0] res_in;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_out;

    // hold the read limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_limit <= READ_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_read_limit <= i_cfg_data;
        end
    end

    swr_front #(
        .FLOWS (FLOWS),
        .SLOTS (SLOTS),
        .FW    (FW),
        .SW    (SW),
        .CMD_W (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_done (init_done),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_flow      (i_flow),
        .i_seq       (i_seq),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    swr_back #(
        .FLOWS (FLOWS),
        .SLOTS (SLOTS),
        .FW    (FW),
        .SW    (SW),
        .CMD_W (CMD_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_read_limit (r_read_limit),
        .o_init_done  (init_done),
        .i_cmd        (cmd),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .o_res        (res_in),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    swr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign {o_ack_flow, o_ack_number, o_window, o_last} = res_out;

endmodule
